/* design/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and facet tables for the tetrahedron facet normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int NUM_FACETS = 6;
    localparam int FACET_BITS = 3;
    localparam int OUT_BITS   = 47;

    typedef logic [1:0] t_vidx;

    // Edge endpoints and the opposite vertex pair of each dual facet.
    function automatic t_vidx edge_a(input logic [FACET_BITS-1:0] f);
        case (f)
            3'd0: edge_a = 2'd2;
            3'd1: edge_a = 2'd1;
            3'd2: edge_a = 2'd1;
            3'd3: edge_a = 2'd3;
            3'd4: edge_a = 2'd2;
            default: edge_a = 2'd1;
        endcase
    endfunction

    function automatic t_vidx edge_b(input logic [FACET_BITS-1:0] f);
        case (f)
            3'd0: edge_b = 2'd3;
            3'd1: edge_b = 2'd3;
            3'd2: edge_b = 2'd2;
            default: edge_b = 2'd0;
        endcase
    endfunction

    function automatic t_vidx opp_a(input logic [FACET_BITS-1:0] f);
        case (f)
            3'd0, 3'd1, 3'd2: opp_a = 2'd0;
            3'd3, 3'd4: opp_a = 2'd1;
            default: opp_a = 2'd2;
        endcase
    endfunction

    function automatic t_vidx opp_b(input logic [FACET_BITS-1:0] f);
        case (f)
            3'd0: opp_b = 2'd1;
            3'd1: opp_b = 2'd2;
            3'd2: opp_b = 2'd3;
            3'd3: opp_b = 2'd2;
            3'd4: opp_b = 2'd3;
            default: opp_b = 2'd3;
        endcase
    endfunction

endpackage

/* design/tetra_facet_normals_unit.sv */
// ----------------------------------------------------------------------------
// tetra_facet_normals_unit
// Dual-facet normals of one tetrahedron, six oriented normals per element.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one tetrahedron per transfer: twelve signed
//    coordinates v0_x..v3_z, packed lowest bits first.
//  - Master stream carries six transfers per element, facets 0..5 in order;
//    tuser = facet_index, tlast marks facet 5. Normals are 32x the true
//    halved normal, exact, sign-oriented away from the opposite vertex pair.
//  - A front sequencer holds the element and issues one facet per cycle
//    into the pipeline while it advances; the slave is ready when the
//    pipeline advances and the held element is on its last facet or empty.
//  - Pipeline: operand select/subtract, 6 products, cross difference,
//    3 dot products, dot sum and sign, then negate into the output register.
//  - Stall: all stages advance only when the output register is free or
//    being taken, so nothing is lost or repeated.
//  - Reset (synchronous, active low) empties every stage; payload is kept.
// ----------------------------------------------------------------------------
module tetra_facet_normals_unit
    import tfn_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, ..., v3_z (COORD_BITS each), zero pad
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // normal_x, normal_y, normal_z (47 bits each), zero pad
    output logic [((3*OUT_BITS+7)/8)*8-1:0]    m_axis_tdata,
    // facet_index
    output logic [FACET_BITS-1:0]    m_axis_tuser,
    output logic                     m_axis_tlast
);

    localparam int CB = COORD_BITS;
    localparam int WB = CB + 3;      // 4*v - sum
    localparam int DB = CB + 1;      // vertex difference
    localparam int PB = 2 * WB;      // product
    localparam int NB = PB + 1;      // cross component
    localparam int TB = NB + DB;     // dot term
    localparam int SB = TB + 2;      // dot sum
    localparam int OW = ((3*OUT_BITS+7)/8)*8;

    typedef logic signed [CB-1:0] t_crd;
    typedef logic signed [WB-1:0] t_w;

    // Pipeline advance: every stage moves together.
    logic adv;
    logic r_ov;
    assign adv = !r_ov || m_axis_tready;

    // ---- Stage 0: element hold and facet sequencer ----
    t_crd r_x [4][3];
    logic r_hv;
    logic [FACET_BITS-1:0] r_f;
    logic last_f;
    assign last_f = (r_f == FACET_BITS'(NUM_FACETS-1));
    assign s_axis_tready = adv && (!r_hv || last_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_f  <= '0;
        end else if (adv) begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_hv <= 1'b1;
                r_f  <= '0;
            end else if (r_hv) begin
                r_hv <= !last_f;
                r_f  <= last_f ? '0 : r_f + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && s_axis_tvalid && s_axis_tready) begin
            for (int i = 0; i < 4; i++)
                for (int c = 0; c < 3; c++)
                    r_x[i][c] <= s_axis_tdata[(i*3+c)*CB +: CB];
        end
    end

    // ---- Stage 1: w vectors of the edge, opposite difference ----
    logic signed [CB+1:0] sum [3];
    t_w n_u [3], n_v [3];
    logic signed [DB-1:0] n_d [3];
    t_w r_u [3], r_v [3];
    logic signed [DB-1:0] r_d1 [3];
    logic r_v1;
    logic [FACET_BITS-1:0] r_f1;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = (CB+2)'(r_x[0][c]) + (CB+2)'(r_x[1][c])
                   + (CB+2)'(r_x[2][c]) + (CB+2)'(r_x[3][c]);
            n_u[c] = (WB'(r_x[edge_a(r_f)][c]) <<< 2) - WB'(sum[c]);
            n_v[c] = (WB'(r_x[edge_b(r_f)][c]) <<< 2) - WB'(sum[c]);
            n_d[c] = DB'(r_x[opp_a(r_f)][c]) - DB'(r_x[opp_b(r_f)][c]);
        end
    end

    // ---- Stage 2: six partial products ----
    logic signed [PB-1:0] r_p [6];
    logic signed [DB-1:0] r_d2 [3];
    logic r_v2;
    logic [FACET_BITS-1:0] r_f2;

    // ---- Stage 3: cross components ----
    logic signed [NB-1:0] r_n3 [3];
    logic signed [DB-1:0] r_d3 [3];
    logic r_v3;
    logic [FACET_BITS-1:0] r_f3;

    // ---- Stage 4: dot terms ----
    logic signed [TB-1:0] r_t [3];
    logic signed [NB-1:0] r_n4 [3];
    logic r_v4;
    logic [FACET_BITS-1:0] r_f4;

    // ---- Stage 5: dot sign ----
    logic r_neg;
    logic signed [NB-1:0] r_n5 [3];
    logic r_v5;
    logic [FACET_BITS-1:0] r_f5;

    // ---- Output register ----
    logic signed [OUT_BITS-1:0] r_o [3];
    logic [FACET_BITS-1:0] r_of;

    logic signed [SB-1:0] dsum;
    assign dsum = SB'(r_t[0]) + SB'(r_t[1]) + SB'(r_t[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_hv; r_v2 <= r_v1; r_v3 <= r_v2;
            r_v4 <= r_v3; r_v5 <= r_v4; r_ov <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u <= n_u; r_v <= n_v; r_d1 <= n_d; r_f1 <= r_f;

            r_p[0] <= PB'(r_u[1]) * PB'(r_v[2]);
            r_p[1] <= PB'(r_u[2]) * PB'(r_v[1]);
            r_p[2] <= PB'(r_u[2]) * PB'(r_v[0]);
            r_p[3] <= PB'(r_u[0]) * PB'(r_v[2]);
            r_p[4] <= PB'(r_u[0]) * PB'(r_v[1]);
            r_p[5] <= PB'(r_u[1]) * PB'(r_v[0]);
            r_d2 <= r_d1; r_f2 <= r_f1;

            r_n3[0] <= NB'(r_p[0]) - NB'(r_p[1]);
            r_n3[1] <= NB'(r_p[2]) - NB'(r_p[3]);
            r_n3[2] <= NB'(r_p[4]) - NB'(r_p[5]);
            r_d3 <= r_d2; r_f3 <= r_f2;

            for (int c = 0; c < 3; c++)
                r_t[c] <= TB'(r_d3[c]) * TB'(r_n3[c]);
            r_n4 <= r_n3; r_f4 <= r_f3;

            r_neg <= dsum[SB-1];
            r_n5 <= r_n4; r_f5 <= r_f4;

            for (int c = 0; c < 3; c++)
                r_o[c] <= r_neg ? OUT_BITS'(-r_n5[c]) : OUT_BITS'(r_n5[c]);
            r_of <= r_f5;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OW'({r_o[2], r_o[1], r_o[0]});
    assign m_axis_tuser  = r_of;
    assign m_axis_tlast  = (r_of == FACET_BITS'(NUM_FACETS-1));

    // ---- Assertions ----
    a_facet_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser < FACET_BITS'(NUM_FACETS)))
        else $error("facet index out of range");
    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> (r_f < FACET_BITS'(NUM_FACETS)))
        else $error("sequencer facet out of range");
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!r_hv || last_f))
        else $error("element accepted while facets pending");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !adv) |=> r_v5)
        else $error("stage lost under stall");

endmodule

/* dv/tetra_facet_normals_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetra_facet_normals_unit_tb
// Self-checking bench: tetrahedra go in on the slave stream, and the six
// oriented facet normals of each one are predicted and compared on the
// master stream under random gaps, stalls and backpressure.
// ----------------------------------------------------------------------------
module tetra_facet_normals_unit_tb;
    import tfn_pkg::*;

    localparam int CB    = 20;
    localparam int IN_W  = ((12*CB+7)/8)*8;
    localparam int OUT_W = ((3*OUT_BITS+7)/8)*8;

    typedef logic signed [CB-1:0] t_coord;
    typedef t_coord t_tetra [12];

    typedef struct packed {
        logic [FACET_BITS-1:0]     facet;
        logic [OUT_BITS-1:0]       nx;
        logic [OUT_BITS-1:0]       ny;
        logic [OUT_BITS-1:0]       nz;
        logic                      last;
    } t_facet_normal;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [FACET_BITS-1:0] m_axis_tuser;
    logic              m_axis_tlast;

    tetra_facet_normals_unit #(.COORD_BITS(CB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    t_facet_normal normals_due[$];
    int  n_errors = 0;
    int  hold_off_cycles = 0;   // forced receiver stall, counted down
    bit  sender_busy = 0;       // receiver randomizes only during sends

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Predict the six oriented normals of one element, exact integer math.
    function automatic void predict_normals(input t_tetra c);
        const int ea[6] = '{2, 1, 1, 3, 2, 1};
        const int eb[6] = '{3, 3, 2, 0, 0, 0};
        const int oa[6] = '{0, 0, 0, 1, 1, 2};
        const int ob[6] = '{1, 2, 3, 2, 3, 3};
        longint x[4][3];
        longint w[4][3];
        longint s[3];
        longint n[3];
        logic signed [127:0] dot;
        t_facet_normal r;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++) x[i][k] = c[i*3+k];
        for (int k = 0; k < 3; k++) s[k] = x[0][k] + x[1][k] + x[2][k] + x[3][k];
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++) w[i][k] = 4*x[i][k] - s[k];
        for (int f = 0; f < 6; f++) begin
            n[0] = w[ea[f]][1]*w[eb[f]][2] - w[ea[f]][2]*w[eb[f]][1];
            n[1] = w[ea[f]][2]*w[eb[f]][0] - w[ea[f]][0]*w[eb[f]][2];
            n[2] = w[ea[f]][0]*w[eb[f]][1] - w[ea[f]][1]*w[eb[f]][0];
            dot = 0;
            for (int k = 0; k < 3; k++)
                dot += 128'(signed'(x[oa[f]][k] - x[ob[f]][k])) * 128'(signed'(n[k]));
            if (dot < 0) for (int k = 0; k < 3; k++) n[k] = -n[k];
            r.facet = f[FACET_BITS-1:0];
            r.nx = n[0][OUT_BITS-1:0];
            r.ny = n[1][OUT_BITS-1:0];
            r.nz = n[2][OUT_BITS-1:0];
            r.last = (f == 5);
            normals_due.push_back(r);
        end
    endfunction

    task automatic send_tetra(input t_tetra c);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 12; i++) d[i*CB +: CB] = c[i];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_normals(c);
        // mostly short gaps, an occasional long one, often none
        if ($urandom_range(0, 2) != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                             : $urandom_range(10, 40))
                @(posedge i_clk);
        end
    endtask

    function automatic t_coord rand_coord(input int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 63) - 32);
            2: return $urandom_range(0, 1) ? t_coord'(20'h7FFFF) : t_coord'(20'h80000);
            default: return t_coord'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Directed: extremes, degenerate and coplanar shapes, zero-dot cases.
    task automatic test_directed;
        t_tetra c;
        t_coord mx, mn;
        mx = 20'h7FFFF;
        mn = 20'h80000;
        c = '{default: 0};
        send_tetra(c);                                   // all coincident
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};       // unit element
        send_tetra(c);
        c = '{0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1};       // other orientation
        send_tetra(c);
        c = '{mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn};
        send_tetra(c);
        c = '{mn, 0, 0, mx, 0, 0, 0, mn, 0, 0, 0, mx};
        send_tetra(c);
        c = '{mx, 0, 0, 0, mx, 0, 0, 0, mx, mn, mn, mn};
        send_tetra(c);
        c = '{0, 0, 0, 5, 0, 0, 0, 5, 0, 5, 5, 0};       // coplanar
        send_tetra(c);
        c = '{1, 2, 3, 2, 4, 6, 3, 6, 9, 4, 8, 12};      // collinear
        send_tetra(c);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
        c[9] = mn; c[10] = mx; c[11] = mn;
        send_tetra(c);
        for (int k = 0; k < 4; k++) begin
            c = '{default: mx};
            c[k*3] = mn;
            send_tetra(c);
        end
        c = '{default: -1};
        send_tetra(c);
        c = '{default: mn};
        send_tetra(c);
        wait_drained();                                  // sender pauses till empty
    endtask

    task automatic test_random(input int count);
        t_tetra c;
        int mode;
        for (int j = 0; j < count; j++) begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 12; i++)
                c[i] = rand_coord($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode);
            send_tetra(c);
        end
    endtask

    // Receiver holds off while the sender keeps offering elements.
    task automatic test_backpressure;
        hold_off_cycles = 300;
        test_random(20);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_busy = 1;
        test_directed();
        test_backpressure();
        wait_drained();
        test_random(230);
        wait_drained();
        sender_busy = 0;
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: forced hold-off first, else random stalls with clean stretches.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end else if (!sender_busy || $urandom_range(0, 99) < 40) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(5, 30)) @(posedge i_clk);
            end
            @(posedge i_clk);
        end
    end

    // Result checker: compare each transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_facet_normal want;
        t_facet_normal got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.facet = m_axis_tuser;
            got.nx    = m_axis_tdata[0 +: OUT_BITS];
            got.ny    = m_axis_tdata[OUT_BITS +: OUT_BITS];
            got.nz    = m_axis_tdata[2*OUT_BITS +: OUT_BITS];
            got.last  = m_axis_tlast;
            if (normals_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: facet %0d", got.facet);
            end else begin
                want = normals_due.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp f%0d %h %h %h l%b / got f%0d %h %h %h l%b",
                                 want.facet, want.nx, want.ny, want.nz, want.last,
                                 got.facet, got.nx, got.ny, got.nz, got.last);
                end
            end
        end
    end

endmodule
